// File: hw/rtl/char_lcd_nibble_writer_assert.svh
// assertion macros used by the lcd nibble writer back end
`ifndef CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define CLN_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("cln assertion failed");
// checked at every edge, reset included
`define CLN_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("cln assertion failed");
`else
`define CLN_ASSERT(name, prop)
`define CLN_ASSERT_ALWAYS(name, prop)
`endif

`endif

// File: hw/rtl/cln_pkg.sv
// shared types and constants for the lcd nibble writer
`default_nettype none

package cln_pkg;

  // input function codes
  typedef enum logic [1:0] {
    FUNC_INIT = 2'd0,
    FUNC_CMD  = 2'd1,
    FUNC_CHAR = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  // work kinds held in the queue
  typedef enum logic [1:0] {
    JOB_INIT,
    JOB_CMD,
    JOB_CHAR
  } job_kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SETUP_HOLD  = 2'd0,
    REG_ENABLE_HIGH = 2'd1,
    REG_NIBBLE_GAP  = 2'd2,
    REG_POWER_UP    = 2'd3
  } reg_idx_e;

  localparam int unsigned TimeW = 20;

  // configuration reset values
  localparam logic [TimeW-1:0] SetupHoldRst  = 20'd3;
  localparam logic [TimeW-1:0] EnableHighRst = 20'd1000;
  localparam logic [TimeW-1:0] NibbleGapRst  = 20'd500;
  localparam logic [TimeW-1:0] PowerUpRst    = 20'd200000;

  // port bit masks and wake-up values
  localparam logic [7:0] E_SET     = 8'b00000100;
  localparam logic [7:0] E_CLR     = 8'b11111011;
  localparam logic [7:0] WAKE_8BIT = 8'b00110000;
  localparam logic [7:0] WAKE_4BIT = 8'b00100000;
  localparam logic [7:0] RS_CLR    = 8'b11111110;
  localparam logic [7:0] RS_SET    = 8'b00000001;
  localparam logic [7:0] HIGH_KEEP = 8'b11110000;
  localparam logic [7:0] LOW_KEEP  = 8'b00001111;

  // last step index of each sequence
  localparam logic [3:0] INIT_LAST = 4'd12;
  localparam logic [3:0] BYTE_LAST = 4'd7;

  typedef struct packed {
    job_kind_e  kind;
    logic [7:0] byte_value;
  } job_t;

  typedef struct packed {
    logic [TimeW-1:0] setup_hold;
    logic [TimeW-1:0] enable_high;
    logic [TimeW-1:0] nibble_gap;
    logic [TimeW-1:0] power_up;
  } cfg_t;

  // queue handshake between front and back
  typedef struct packed {
    logic full;
    logic head_valid;
  } q_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/cln_front.sv
// front end: takes input items, decodes the function and drops unused codes
`default_nettype none

module cln_front import cln_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [7:0] byte_value_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output job_t       job_o
);

  func_e func;
  logic  keep;

  assign func = func_e'(func_i);

  // function decode
  always_comb begin
    job_o.byte_value = byte_value_i;
    job_o.kind       = JOB_INIT;
    keep             = 1'b1;
    unique case (func)
      FUNC_INIT: job_o.kind = JOB_INIT;
      FUNC_CMD:  job_o.kind = JOB_CMD;
      FUNC_CHAR: job_o.kind = JOB_CHAR;
      default:   keep       = 1'b0;
    endcase
  end

  // accept while the queue has room, push only real work
  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full && keep;

endmodule

`default_nettype wire

// File: hw/rtl/cln_queue.sv
// two-entry queue of decoded items between front and back
`default_nettype none

module cln_queue import cln_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      head_o,
  output q_status_t status_o
);

  job_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  // pointer and count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o              = entry_q[rd_ptr_q];
  assign status_o.full       = (count_q == 2'd2);
  assign status_o.head_valid = (count_q != 2'd0);

endmodule

`default_nettype wire

// File: hw/rtl/cln_back.sv
// back end: steps the head item's port writes, one per unstalled cycle
`default_nettype none

module cln_back import cln_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  job_t             head_i,
  input  q_status_t        q_status_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       port_value_o,
  output logic [TimeW-1:0] hold_us_o,
  output logic             last_write_o
);

  `include "char_lcd_nibble_writer_assert.svh"

  logic [3:0]       step_q, step_d;
  logic [7:0]       image_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       port_value_q;
  logic [TimeW-1:0] hold_q;
  logic             last_q;

  logic             advance;
  logic [7:0]       val;
  logic [TimeW-1:0] hold;
  logic             last;
  logic [3:0]       nib;
  logic             rs;

  // write value for the current step
  always_comb begin
    nib  = step_q[2] ? head_i.byte_value[3:0] : head_i.byte_value[7:4];
    rs   = (head_i.kind == JOB_CHAR);
    val  = image_q;
    hold = cfg_i.setup_hold;
    last = 1'b0;
    if (head_i.kind == JOB_INIT) begin
      unique case (step_q) inside
        4'd0: begin
          val  = image_q & RS_CLR;
          hold = cfg_i.power_up;
        end
        4'd1, 4'd4, 4'd7, 4'd3, 4'd6, 4'd9: val = WAKE_8BIT;
        4'd2, 4'd5, 4'd8: begin
          val  = WAKE_8BIT | E_SET;
          hold = cfg_i.enable_high;
        end
        4'd10: val = WAKE_4BIT;
        4'd11: begin
          val  = WAKE_4BIT | E_SET;
          hold = cfg_i.enable_high;
        end
        4'd12: begin
          val  = WAKE_4BIT;
          hold = '0;
        end
        default: val = image_q;
      endcase
      last = (step_q == INIT_LAST);
    end else begin
      case (step_q[1:0])
        2'd0: val = (image_q & LOW_KEEP) | ({nib, 4'b0000} & HIGH_KEEP);
        2'd1: val = rs ? (image_q | RS_SET) : (image_q & RS_CLR);
        2'd2: begin
          val  = image_q | E_SET;
          hold = cfg_i.enable_high;
        end
        default: begin
          val  = image_q & E_CLR;
          hold = cfg_i.nibble_gap;
        end
      endcase
      last = (step_q == BYTE_LAST);
    end
  end

  // sequencing and output register handshake
  assign advance = q_status_i.head_valid && (!out_valid_q || !out_stall_i);
  assign pop_o   = advance && last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      step_d      = last ? 4'd0 : step_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 4'd0;
      image_q     <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        image_q <= val;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      port_value_q <= val;
      hold_q       <= hold;
      last_q       <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign port_value_o = port_value_q;
  assign hold_us_o    = hold_q;
  assign last_write_o = last_q;

  `CLN_ASSERT(a_step_range, step_q <= INIT_LAST)
  `CLN_ASSERT(a_byte_step_range,
    (q_status_i.head_valid && head_i.kind != JOB_INIT) |-> (step_q <= BYTE_LAST))
  `CLN_ASSERT(a_last_restarts, (advance && last) |=> (step_q == 4'd0))
  `CLN_ASSERT(a_image_tracks_out, out_valid_q |-> (image_q == port_value_q))

endmodule

`default_nettype wire

// File: hw/rtl/char_lcd_nibble_writer.sv
// character lcd 4-bit nibble writer top level
// Drives an hd44780-style lcd hung on an 8-bit port (bit0 RS, bit2 E,
// bits 4-7 data). Each input item (valid/stall) asks for the init
// sequence, a command byte or a character byte; func 3 is taken and dropped.
// Each item yields a burst of result items (valid/stall) on the output,
// one port value with its hold time in microseconds, last_write marking
// the final one: 13 writes for init, 8 for a command or character.
// The first write of an item passes through the queue and then the output
// register. The back end emits one write per cycle while the receiver does
// not stall, and the two-entry queue holds the item in progress and lets
// one more item wait behind it.
// When the receiver stalls, the output register holds its item and the
// sequencer waits; the queue fills and then stalls the input. Reset clears
// the queue, the sequencer, the port image and sets the four timing
// registers to 3, 1000, 500 and 200000 us. The user must write them through
// cfg_we_i/cfg_idx_i/cfg_wdata_i only while idle; the block does not check.
`default_nettype none

module char_lcd_nibble_writer import cln_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [TimeW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       func_i,
  input  logic [7:0]       byte_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       port_value_o,
  output logic [TimeW-1:0] hold_us_o,
  output logic             last_write_o
);

  cfg_t      cfg_q;
  reg_idx_e  cfg_idx;
  q_status_t q_status;
  logic      push;
  logic      pop;
  job_t      job;
  job_t      head;

  assign cfg_idx = reg_idx_e'(cfg_idx_i);

  // timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setup_hold  <= SetupHoldRst;
      cfg_q.enable_high <= EnableHighRst;
      cfg_q.nibble_gap  <= NibbleGapRst;
      cfg_q.power_up    <= PowerUpRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        REG_SETUP_HOLD:  cfg_q.setup_hold  <= cfg_wdata_i;
        REG_ENABLE_HIGH: cfg_q.enable_high <= cfg_wdata_i;
        REG_NIBBLE_GAP:  cfg_q.nibble_gap  <= cfg_wdata_i;
        default:         cfg_q.power_up    <= cfg_wdata_i;
      endcase
    end
  end

  cln_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .byte_value_i (byte_value_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .job_o        (job)
  );

  cln_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  cln_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .port_value_o (port_value_o),
    .hold_us_o    (hold_us_o),
    .last_write_o (last_write_o)
  );

endmodule

`default_nettype wire
